/* rtl/core/l2c_pkg.sv */
// shared types and constants of the lba to chs task-file sequencer
package l2c_pkg;

  // field widths
  localparam int unsigned LBA_W   = 28;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned HPC_W   = 5;
  localparam int unsigned SPT_W   = 8;
  localparam int unsigned PCYL_W  = 12;
  localparam int unsigned HEAD_W  = 4;
  localparam int unsigned OFS_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HPC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRV = 2'd2;

  // configuration reset values and head limit
  localparam logic [HPC_W-1:0] HPC_RST   = 5'd16;
  localparam logic [SPT_W-1:0] SPT_RST   = 8'd63;
  localparam logic [HPC_W-1:0] HPC_MAX   = 5'd16;

  // task-file register offsets
  localparam logic [OFS_W-1:0] OFS_COUNT   = 3'd2;
  localparam logic [OFS_W-1:0] OFS_SECTOR  = 3'd3;
  localparam logic [OFS_W-1:0] OFS_CYL_LO  = 3'd4;
  localparam logic [OFS_W-1:0] OFS_CYL_HI  = 3'd5;
  localparam logic [OFS_W-1:0] OFS_DRVHEAD = 3'd6;
  localparam logic [OFS_W-1:0] OFS_CMD     = 3'd7;

  // register values
  localparam logic [BYTE_W-1:0] CMD_READ    = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_WRITE   = 8'h30;
  localparam logic [BYTE_W-1:0] DRV_MASTER  = 8'hA0;
  localparam logic [BYTE_W-1:0] DRV_SLAVE   = 8'hB0;
  localparam logic [BYTE_W-1:0] CYL_SAT     = 8'hFF;
  localparam logic [15:0]       CYL_LO_MASK = 16'h00FF;

  // beats of one request, in bus order
  typedef enum logic [2:0] {
    BEAT_DRVHEAD,
    BEAT_COUNT,
    BEAT_SECTOR,
    BEAT_CYL_LO,
    BEAT_CYL_HI,
    BEAT_CMD
  } beat_t;

  // finished conversion handed to the beat sequencer
  typedef struct packed {
    logic              wr;
    logic [CNT_W-1:0]  count;
    logic [LBA_W-1:0]  cyl;
    logic [HEAD_W-1:0] head;
    logic [SPT_W-1:0]  sect0;
  } job_t;

endpackage

/* rtl/core/l2c_if.sv */
// request and task-file write channel interfaces
interface l2c_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [l2c_pkg::LBA_W-1:0] lba_addr;
  logic [l2c_pkg::CNT_W-1:0] sector_count;

  modport source (output valid, req_type, lba_addr, sector_count, input ready);
  modport sink   (input valid, req_type, lba_addr, sector_count, output ready);
endinterface

interface l2c_wr_if;
  logic                       valid;
  logic                       ready;
  logic [l2c_pkg::OFS_W-1:0]  reg_offset;
  logic [l2c_pkg::BYTE_W-1:0] reg_value;
  logic                       last_write;
  logic                       cyl_overflow;

  modport source (output valid, reg_offset, reg_value, last_write, cyl_overflow,
                  input ready);
  modport sink   (input valid, reg_offset, reg_value, last_write, cyl_overflow,
                  output ready);
endinterface

/* rtl/core/l2c_div_cell.sv */
// one restoring division step, registered, with pass-along side data
module l2c_div_cell #(
  parameter int unsigned DW = 28,
  parameter int unsigned VW = 12,
  parameter int unsigned SW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [VW-1:0] divisor,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VW-1:0] in_rem,
  input  logic [DW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_rem,
  output logic [DW-1:0] out_num,
  output logic [SW-1:0] out_side
);

  logic          valid_r;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] num_r, num_nxt;
  logic [SW-1:0] side_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {in_rem, in_num[DW-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    num_nxt = {in_num[DW-2:0], ge};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_side  = side_r;

endmodule

/* rtl/core/l2c_div_chain.sv */
// row of division cells, one quotient bit per cell
module l2c_div_chain #(
  parameter int unsigned DW = 28,
  parameter int unsigned VW = 12,
  parameter int unsigned SW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [VW-1:0] divisor,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VW-1:0] in_rem,
  input  logic [DW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_rem,
  output logic [DW-1:0] out_num,
  output logic [SW-1:0] out_side
);

  logic          vld  [0:DW];
  logic          rdy  [0:DW];
  logic [VW-1:0] rem  [0:DW];
  logic [DW-1:0] num  [0:DW];
  logic [SW-1:0] side [0:DW];

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];
  assign rem[0]   = in_rem;
  assign num[0]   = in_num;
  assign side[0]  = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    l2c_div_cell #(
      .DW (DW),
      .VW (VW),
      .SW (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (divisor),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_rem    (rem[i]),
      .in_num    (num[i]),
      .in_side   (side[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_rem   (rem[i+1]),
      .out_num   (num[i+1]),
      .out_side  (side[i+1])
    );
  end

  assign out_valid = vld[DW];
  assign rdy[DW]   = out_ready;
  assign out_rem   = rem[DW];
  assign out_num   = num[DW];
  assign out_side  = side[DW];

endmodule

/* rtl/core/l2c_tf_seq.sv */
// holds one converted request and plays out its six task-file beats
module l2c_tf_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            drive_slave,
  input  logic            in_valid,
  output logic            in_ready,
  input  l2c_pkg::job_t   in_job,
  l2c_wr_if.source        out_wr
);

  l2c_pkg::beat_t              beat_r, beat_nxt;
  logic                        busy_r, busy_nxt;
  logic                        wr_r;
  logic [l2c_pkg::CNT_W-1:0]   count_r;
  logic [l2c_pkg::SPT_W-1:0]   sect_r;
  logic [l2c_pkg::HEAD_W-1:0]  head_r;
  logic [l2c_pkg::BYTE_W-1:0]  lo_r, hi_r;
  logic                        ovf_r;
  logic                        fire, done, load, ovf;
  logic [15:0]                 cyl16;

  assign fire     = out_wr.valid && out_wr.ready;
  assign done     = fire && (beat_r == l2c_pkg::BEAT_CMD);
  assign in_ready = !busy_r || done;
  assign load     = in_valid && in_ready;

  // next beat and busy flag
  always_comb begin
    beat_nxt = beat_r;
    if (fire) begin
      unique case (beat_r)
        l2c_pkg::BEAT_DRVHEAD: beat_nxt = l2c_pkg::BEAT_COUNT;
        l2c_pkg::BEAT_COUNT:   beat_nxt = l2c_pkg::BEAT_SECTOR;
        l2c_pkg::BEAT_SECTOR:  beat_nxt = l2c_pkg::BEAT_CYL_LO;
        l2c_pkg::BEAT_CYL_LO:  beat_nxt = l2c_pkg::BEAT_CYL_HI;
        l2c_pkg::BEAT_CYL_HI:  beat_nxt = l2c_pkg::BEAT_CMD;
        l2c_pkg::BEAT_CMD:     beat_nxt = l2c_pkg::BEAT_DRVHEAD;
        default:               beat_nxt = l2c_pkg::BEAT_DRVHEAD;
      endcase
    end
    busy_nxt = busy_r;
    if (done) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= l2c_pkg::BEAT_DRVHEAD;
      busy_r <= 1'b0;
    end else begin
      beat_r <= beat_nxt;
      busy_r <= busy_nxt;
    end
  end

  // saturate the cylinder bytes on overflow
  always_comb begin
    ovf   = |in_job.cyl[l2c_pkg::LBA_W-1:16];
    cyl16 = in_job.cyl[15:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr_r    <= in_job.wr;
      count_r <= in_job.count;
      sect_r  <= l2c_pkg::SPT_W'(in_job.sect0 + 8'd1);
      head_r  <= in_job.head;
      ovf_r   <= ovf;
      lo_r    <= ovf ? l2c_pkg::CYL_SAT : 8'(cyl16 & l2c_pkg::CYL_LO_MASK);
      hi_r    <= ovf ? l2c_pkg::CYL_SAT : cyl16[15:8];
    end
  end

  // beat payload
  always_comb begin
    out_wr.reg_offset = l2c_pkg::OFS_DRVHEAD;
    out_wr.reg_value  = '0;
    out_wr.last_write = 1'b0;
    unique case (beat_r)
      l2c_pkg::BEAT_DRVHEAD: begin
        out_wr.reg_offset = l2c_pkg::OFS_DRVHEAD;
        out_wr.reg_value  = (drive_slave ? l2c_pkg::DRV_SLAVE : l2c_pkg::DRV_MASTER)
                            | {4'h0, head_r};
      end
      l2c_pkg::BEAT_COUNT: begin
        out_wr.reg_offset = l2c_pkg::OFS_COUNT;
        out_wr.reg_value  = count_r;
      end
      l2c_pkg::BEAT_SECTOR: begin
        out_wr.reg_offset = l2c_pkg::OFS_SECTOR;
        out_wr.reg_value  = sect_r;
      end
      l2c_pkg::BEAT_CYL_LO: begin
        out_wr.reg_offset = l2c_pkg::OFS_CYL_LO;
        out_wr.reg_value  = lo_r;
      end
      l2c_pkg::BEAT_CYL_HI: begin
        out_wr.reg_offset = l2c_pkg::OFS_CYL_HI;
        out_wr.reg_value  = hi_r;
      end
      l2c_pkg::BEAT_CMD: begin
        out_wr.reg_offset = l2c_pkg::OFS_CMD;
        out_wr.reg_value  = wr_r ? l2c_pkg::CMD_WRITE : l2c_pkg::CMD_READ;
        out_wr.last_write = 1'b1;
      end
      default: begin
        out_wr.reg_offset = l2c_pkg::OFS_DRVHEAD;
        out_wr.reg_value  = '0;
        out_wr.last_write = 1'b0;
      end
    endcase
  end

  assign out_wr.valid        = busy_r;
  assign out_wr.cyl_overflow = ovf_r;

endmodule

/* rtl/core/lba_to_chs_taskfile.sv */
// top level: lba to chs conversion and task-file write sequencer
//
// channel   dir  handshake      payload
// in_req    in   valid/ready    req_type, lba_addr, sector_count
// out_wr    out  valid/ready    reg_offset, reg_value, last_write, cyl_overflow
// cfg_*     in   cfg_we only    cfg_idx, cfg_wdata (heads, sectors, drive select)
//
// every request gives six beats on out_wr, one per cycle while out_wr.ready is high,
// so the beat sequencer sets the request rate; it loads the next request as its last beat goes
// a request passes 28 cells for the cylinder quotient and 4 cells for the head quotient,
// then is loaded into the sequencer, which presents its first task-file beat
// the cell row holds one request per cell; a stall on out_wr backs up cell by
// cell, and bubbles between requests close up as they move
// synchronous active-low reset clears the configuration to 16 heads, 63 sectors,
// master drive, and empties all cells and the sequencer
module lba_to_chs_taskfile (
  input  logic                          clk,
  input  logic                          rst_n,
  l2c_req_if.sink                       in_req,
  l2c_wr_if.source                      out_wr,
  input  logic                          cfg_we,
  input  logic [l2c_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [l2c_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  // side data widths: {req_type, count} then {req_type, count, cylinder}
  localparam int unsigned SIDE1_W = 1 + l2c_pkg::CNT_W;
  localparam int unsigned SIDE2_W = SIDE1_W + l2c_pkg::LBA_W;

  // geometry registers
  logic [l2c_pkg::HPC_W-1:0]  hpc_r;
  logic [l2c_pkg::SPT_W-1:0]  spt_r;
  logic                       slave_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpc_r   <= l2c_pkg::HPC_RST;
      spt_r   <= l2c_pkg::SPT_RST;
      slave_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        l2c_pkg::REG_HPC: hpc_r   <= cfg_wdata[l2c_pkg::HPC_W-1:0];
        l2c_pkg::REG_SPT: spt_r   <= cfg_wdata[l2c_pkg::SPT_W-1:0];
        l2c_pkg::REG_DRV: slave_r <= cfg_wdata[0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // usable geometry: zero counts as one, more than sixteen heads as sixteen
  logic [l2c_pkg::HPC_W-1:0]  hpc_eff;
  logic [l2c_pkg::SPT_W-1:0]  spt_eff;
  logic [12:0]                per_cyl_prod;
  logic [l2c_pkg::PCYL_W-1:0] per_cyl;

  always_comb begin
    if (hpc_r == '0) begin
      hpc_eff = l2c_pkg::HPC_W'(1);
    end else if (hpc_r > l2c_pkg::HPC_MAX) begin
      hpc_eff = l2c_pkg::HPC_MAX;
    end else begin
      hpc_eff = hpc_r;
    end
    spt_eff      = (spt_r == '0) ? l2c_pkg::SPT_W'(1) : spt_r;
    // at most 16 x 255, so twelve bits hold it
    per_cyl_prod = 13'(hpc_eff) * 13'(spt_eff);
    per_cyl      = per_cyl_prod[l2c_pkg::PCYL_W-1:0];
  end

  // cylinder row: lba / (heads x sectors), remainder left in rem1
  logic                        c1_valid, c1_ready;
  logic [l2c_pkg::PCYL_W-1:0]  c1_rem;
  logic [l2c_pkg::LBA_W-1:0]   c1_cyl;
  logic [SIDE1_W-1:0]          c1_side;

  l2c_div_chain #(
    .DW (l2c_pkg::LBA_W),
    .VW (l2c_pkg::PCYL_W),
    .SW (SIDE1_W)
  ) u_cyl_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .divisor   (per_cyl),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .in_rem    ('0),
    .in_num    (in_req.lba_addr),
    .in_side   ({in_req.req_type, in_req.sector_count}),
    .out_valid (c1_valid),
    .out_ready (c1_ready),
    .out_rem   (c1_rem),
    .out_num   (c1_cyl),
    .out_side  (c1_side)
  );

  // head row: rem1 / sectors; rem1 < 16 x sectors, so its top eight bits are
  // already below the divisor and only four quotient bits remain
  logic                        c2_valid, c2_ready;
  logic [l2c_pkg::SPT_W-1:0]   c2_rem;
  logic [l2c_pkg::HEAD_W-1:0]  c2_head;
  logic [SIDE2_W-1:0]          c2_side;

  l2c_div_chain #(
    .DW (l2c_pkg::HEAD_W),
    .VW (l2c_pkg::SPT_W),
    .SW (SIDE2_W)
  ) u_head_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .divisor   (spt_eff),
    .in_valid  (c1_valid),
    .in_ready  (c1_ready),
    .in_rem    (c1_rem[l2c_pkg::PCYL_W-1:l2c_pkg::HEAD_W]),
    .in_num    (c1_rem[l2c_pkg::HEAD_W-1:0]),
    .in_side   ({c1_side, c1_cyl}),
    .out_valid (c2_valid),
    .out_ready (c2_ready),
    .out_rem   (c2_rem),
    .out_num   (c2_head),
    .out_side  (c2_side)
  );

  // converted request
  l2c_pkg::job_t job;

  always_comb begin
    job.wr    = c2_side[SIDE2_W-1];
    job.count = c2_side[SIDE2_W-2:l2c_pkg::LBA_W];
    job.cyl   = c2_side[l2c_pkg::LBA_W-1:0];
    job.head  = c2_head;
    job.sect0 = c2_rem;
  end

  l2c_tf_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .drive_slave (slave_r),
    .in_valid    (c2_valid),
    .in_ready    (c2_ready),
    .in_job      (job),
    .out_wr      (out_wr)
  );

endmodule

/* rtl/core/l2c_checker.sv */
// port-level checks on the task-file write channel, bound to the top level
module l2c_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [l2c_pkg::OFS_W-1:0]   reg_offset,
  input logic [l2c_pkg::BYTE_W-1:0]  reg_value,
  input logic                        last_write,
  input logic                        cyl_overflow
);

  // a stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reg_offset) && $stable(reg_value))
    else $error("stalled task-file beat changed");

  // a run never pauses between its beats
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_write |=> out_valid)
    else $error("gap inside a task-file run");

  // overflow flag is the same on every beat of a run
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_write |=> cyl_overflow == $past(cyl_overflow))
    else $error("cyl_overflow changed inside a run");

  // the count write follows the drive/head write
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && reg_offset == l2c_pkg::OFS_DRVHEAD
    |=> reg_offset == l2c_pkg::OFS_COUNT)
    else $error("count beat does not follow drive/head beat");

endmodule

bind lba_to_chs_taskfile l2c_checker u_l2c_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_wr.valid),
  .out_ready    (out_wr.ready),
  .reg_offset   (out_wr.reg_offset),
  .reg_value    (out_wr.reg_value),
  .last_write   (out_wr.last_write),
  .cyl_overflow (out_wr.cyl_overflow)
);
